>>> design/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, constants and jamo tables for the two-set Hangul composer.
// ----------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

  // Event kinds carried on the input tuser.
  localparam logic [3:0] MODE_KEY       = 4'd0;
  localparam logic [3:0] MODE_BACKSPACE = 4'd1;
  localparam logic [3:0] MODE_ENTER     = 4'd2;
  localparam logic [3:0] MODE_TAB       = 4'd3;
  localparam logic [3:0] MODE_RESET     = 4'd4;

  localparam int KEY_W  = 21;
  localparam int CODE_W = 16;
  localparam int OUT_W  = 40;

  localparam logic [4:0] NONE_IDX    = 5'd31;
  localparam logic [4:0] SILENT_LEAD = 5'd11;
  localparam logic [4:0] N_LEAD      = 5'd19;
  localparam logic [4:0] N_VOWEL     = 5'd21;
  localparam logic [4:0] N_TAIL      = 5'd28;

  localparam logic [CODE_W-1:0] SYL_BASE   = 16'hAC00;
  localparam logic [CODE_W-1:0] LEAD_BASE  = 16'h3131;
  localparam logic [CODE_W-1:0] VOWEL_BASE = 16'h314F;
  localparam logic [CODE_W-1:0] BAD_CODE   = 16'h003F;

  // Composition state: lead, vowel and tail indices plus flags.
  typedef struct packed {
    logic       composing;
    logic       implied;
    logic [4:0] lead;
    logic [4:0] vowel;
    logic [4:0] tail;
  } comp_state_t;

  localparam comp_state_t IDLE_STATE = '{composing: 1'b0, implied: 1'b0,
                                         lead: NONE_IDX, vowel: NONE_IDX,
                                         tail: 5'd0};

  // Result of a table search: hit flag and the index found.
  typedef struct packed {
    logic       hit;
    logic [4:0] idx;
  } lookup_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic load_in;
    logic eval;
    logic load_out;
  } hsc_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_BUILD
  } hsc_state_t;

  // Key to lead consonant.
  function automatic lookup_t lead_key(input logic [6:0] key);
    lookup_t r;
    r.hit = 1'b1;
    case (key)
      7'h72: r.idx = 5'd0;
      7'h52: r.idx = 5'd1;
      7'h73: r.idx = 5'd2;
      7'h65: r.idx = 5'd3;
      7'h45: r.idx = 5'd4;
      7'h66: r.idx = 5'd5;
      7'h61: r.idx = 5'd6;
      7'h71: r.idx = 5'd7;
      7'h51: r.idx = 5'd8;
      7'h74: r.idx = 5'd9;
      7'h54: r.idx = 5'd10;
      7'h64: r.idx = 5'd11;
      7'h77: r.idx = 5'd12;
      7'h57: r.idx = 5'd13;
      7'h63: r.idx = 5'd14;
      7'h7A: r.idx = 5'd15;
      7'h78: r.idx = 5'd16;
      7'h76: r.idx = 5'd17;
      7'h67: r.idx = 5'd18;
      default: begin
        r.hit = 1'b0;
        r.idx = 5'd0;
      end
    endcase
    return r;
  endfunction

  // Key to vowel.
  function automatic lookup_t vowel_key(input logic [6:0] key);
    lookup_t r;
    r.hit = 1'b1;
    case (key)
      7'h6B: r.idx = 5'd0;
      7'h6F: r.idx = 5'd1;
      7'h69: r.idx = 5'd2;
      7'h4F: r.idx = 5'd3;
      7'h6A: r.idx = 5'd4;
      7'h70: r.idx = 5'd5;
      7'h75: r.idx = 5'd6;
      7'h50: r.idx = 5'd7;
      7'h68: r.idx = 5'd8;
      7'h79: r.idx = 5'd12;
      7'h6E: r.idx = 5'd13;
      7'h62: r.idx = 5'd17;
      7'h6D: r.idx = 5'd18;
      7'h6C: r.idx = 5'd20;
      default: begin
        r.hit = 1'b0;
        r.idx = 5'd0;
      end
    endcase
    return r;
  endfunction

  // Tail form of a lead consonant; zero when it has none.
  function automatic logic [4:0] tail_of_lead(input logic [4:0] l);
    logic [4:0] r;
    case (l)
      5'd0:  r = 5'd1;
      5'd1:  r = 5'd2;
      5'd2:  r = 5'd4;
      5'd3:  r = 5'd7;
      5'd5:  r = 5'd8;
      5'd6:  r = 5'd16;
      5'd7:  r = 5'd17;
      5'd9:  r = 5'd19;
      5'd10: r = 5'd20;
      5'd11: r = 5'd21;
      5'd12: r = 5'd22;
      5'd14: r = 5'd23;
      5'd15: r = 5'd24;
      5'd16: r = 5'd25;
      5'd17: r = 5'd26;
      5'd18: r = 5'd27;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Lead form of a single tail; NONE_IDX when it has none.
  function automatic logic [4:0] lead_of_tail(input logic [4:0] t);
    logic [4:0] r;
    case (t)
      5'd1:  r = 5'd0;
      5'd2:  r = 5'd1;
      5'd4:  r = 5'd2;
      5'd7:  r = 5'd3;
      5'd8:  r = 5'd5;
      5'd16: r = 5'd6;
      5'd17: r = 5'd7;
      5'd19: r = 5'd9;
      5'd20: r = 5'd10;
      5'd21: r = 5'd11;
      5'd22: r = 5'd12;
      5'd23: r = 5'd14;
      5'd24: r = 5'd15;
      5'd25: r = 5'd16;
      5'd26: r = 5'd17;
      5'd27: r = 5'd18;
      default: r = NONE_IDX;
    endcase
    return r;
  endfunction

  // First tail of a tail cluster; zero when the tail is not a cluster.
  function automatic logic [4:0] split_first(input logic [4:0] t);
    logic [4:0] r;
    case (t)
      5'd3:  r = 5'd1;
      5'd5,
      5'd6:  r = 5'd4;
      5'd9, 5'd10, 5'd11, 5'd12,
      5'd13, 5'd14, 5'd15: r = 5'd8;
      5'd18: r = 5'd17;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Lead that the second half of a tail cluster becomes.
  function automatic logic [4:0] split_second(input logic [4:0] t);
    logic [4:0] r;
    case (t)
      5'd3:  r = 5'd9;
      5'd5:  r = 5'd12;
      5'd6:  r = 5'd18;
      5'd10: r = 5'd6;
      5'd11: r = 5'd7;
      5'd12: r = 5'd9;
      5'd13: r = 5'd16;
      5'd14: r = 5'd17;
      5'd15: r = 5'd18;
      5'd18: r = 5'd9;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // First half of a compound vowel; NONE_IDX when the vowel is simple.
  function automatic logic [4:0] vow_first(input logic [4:0] v);
    logic [4:0] r;
    case (v)
      5'd9, 5'd10, 5'd11:  r = 5'd8;
      5'd14, 5'd15, 5'd16: r = 5'd13;
      5'd19:               r = 5'd18;
      default:             r = NONE_IDX;
    endcase
    return r;
  endfunction

  // Compound vowel built from two vowels.
  function automatic lookup_t combine_vowel(input logic [4:0] a, input logic [4:0] b);
    lookup_t r;
    r.hit = 1'b1;
    case ({a, b})
      {5'd8, 5'd0}:   r.idx = 5'd9;
      {5'd8, 5'd1}:   r.idx = 5'd10;
      {5'd8, 5'd20}:  r.idx = 5'd11;
      {5'd13, 5'd4}:  r.idx = 5'd14;
      {5'd13, 5'd5}:  r.idx = 5'd15;
      {5'd13, 5'd20}: r.idx = 5'd16;
      {5'd18, 5'd20}: r.idx = 5'd19;
      default: begin
        r.hit = 1'b0;
        r.idx = 5'd0;
      end
    endcase
    return r;
  endfunction

  // Tail cluster built from a tail and a following lead.
  function automatic lookup_t combine_tail(input logic [4:0] t, input logic [4:0] l);
    lookup_t r;
    r.hit = 1'b1;
    case ({t, l})
      {5'd1, 5'd9}:   r.idx = 5'd3;
      {5'd4, 5'd12}:  r.idx = 5'd5;
      {5'd4, 5'd18}:  r.idx = 5'd6;
      {5'd8, 5'd0}:   r.idx = 5'd9;
      {5'd8, 5'd6}:   r.idx = 5'd10;
      {5'd8, 5'd7}:   r.idx = 5'd11;
      {5'd8, 5'd9}:   r.idx = 5'd12;
      {5'd8, 5'd16}:  r.idx = 5'd13;
      {5'd8, 5'd17}:  r.idx = 5'd14;
      {5'd8, 5'd18}:  r.idx = 5'd15;
      {5'd17, 5'd9}:  r.idx = 5'd18;
      default: begin
        r.hit = 1'b0;
        r.idx = 5'd0;
      end
    endcase
    return r;
  endfunction

  // Compatibility jamo of a lead consonant.
  function automatic logic [CODE_W-1:0] lead_jamo(input logic [4:0] l);
    logic [CODE_W-1:0] r;
    case (l)
      5'd0:  r = 16'h3131;
      5'd1:  r = 16'h3132;
      5'd2:  r = 16'h3134;
      5'd3:  r = 16'h3137;
      5'd4:  r = 16'h3138;
      5'd5:  r = 16'h3139;
      5'd6:  r = 16'h3141;
      5'd7:  r = 16'h3142;
      5'd8:  r = 16'h3143;
      5'd9:  r = 16'h3145;
      5'd10: r = 16'h3146;
      5'd11: r = 16'h3147;
      5'd12: r = 16'h3148;
      5'd13: r = 16'h3149;
      5'd14: r = 16'h314A;
      5'd15: r = 16'h314B;
      5'd16: r = 16'h314C;
      5'd17: r = 16'h314D;
      5'd18: r = 16'h314E;
      default: r = BAD_CODE;
    endcase
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] vowel_jamo(input logic [4:0] v);
    return (v < N_VOWEL) ? VOWEL_BASE + CODE_W'(v) : BAD_CODE;
  endfunction

  // Precomposed syllable from lead, vowel and tail indices.
  function automatic logic [CODE_W-1:0] syllable(input logic [4:0] l, input logic [4:0] v,
                                                 input logic [4:0] t);
    logic [CODE_W-1:0] lv;
    lv = CODE_W'(l) * CODE_W'(N_VOWEL) + CODE_W'(v);
    if (l >= N_LEAD || v >= N_VOWEL || t >= N_TAIL) begin
      return BAD_CODE;
    end
    return SYL_BASE + lv * CODE_W'(N_TAIL) + CODE_W'(t);
  endfunction

  // Preview code point of a composition state; zero when idle.
  function automatic logic [CODE_W-1:0] preview(input comp_state_t s);
    logic hl;
    logic hv;
    hl = (s.lead != NONE_IDX);
    hv = (s.vowel != NONE_IDX);
    if (!s.composing) begin
      return '0;
    end
    if (s.implied && hv && s.tail == 5'd0) begin
      return vowel_jamo(s.vowel);
    end
    if (hl && hv) begin
      return syllable(s.lead, s.vowel, s.tail);
    end
    if (hl) begin
      return lead_jamo(s.lead);
    end
    if (hv) begin
      return vowel_jamo(s.vowel);
    end
    return '0;
  endfunction

endpackage

`default_nettype wire

>>> design/hsc_datapath.sv
// ----------------------------------------------------------------------------
// hsc_datapath
// Event register, composition state, commit snapshot and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_datapath (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire hsc_pkg::hsc_cmd_t       cmd,
  input  wire logic [3:0]              in_mode,
  input  wire logic [hsc_pkg::KEY_W-1:0] in_key,
  output logic [hsc_pkg::OUT_W-1:0]    result
);
  import hsc_pkg::*;

  logic [3:0]       mode;
  logic [KEY_W-1:0] key;
  comp_state_t      state;
  comp_state_t      state_next;
  comp_state_t      snap;
  comp_state_t      snap_next;
  logic             consumed;
  logic             consumed_next;
  logic             show;
  logic             show_next;

  lookup_t          lk;
  lookup_t          vk;
  lookup_t          cv;
  lookup_t          ct;
  logic             key_ok;
  logic [4:0]       tl;
  logic [4:0]       lt;
  logic [4:0]       vb;
  logic [CODE_W-1:0] pre_code;
  logic [CODE_W-1:0] commit_code;

  // Event register, loaded on an input transfer.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode <= in_mode;
      key  <= in_key;
    end
  end

  // Table lookups on the held event and state.
  always_comb begin
    key_ok = (key[KEY_W-1:7] == '0);
    lk     = lead_key(key[6:0]);
    vk     = vowel_key(key[6:0]);
    cv     = combine_vowel(state.vowel, vk.idx);
    ct     = combine_tail(state.tail, lk.idx);
    tl     = tail_of_lead(lk.idx);
    lt     = lead_of_tail(state.tail);
    vb     = vow_first(state.vowel);
  end

  // Automaton step: next state and the state whose preview gets committed.
  always_comb begin
    state_next    = state;
    snap_next     = IDLE_STATE;
    consumed_next = 1'b0;
    show_next     = 1'b0;
    unique case (mode)
      MODE_BACKSPACE: begin
        if (state.composing) begin
          consumed_next = 1'b1;
          show_next     = 1'b1;
          if (state.tail != 5'd0) begin
            state_next.tail = split_first(state.tail);
          end else if (state.vowel != NONE_IDX) begin
            if (vb != NONE_IDX) begin
              state_next.vowel = vb;
            end else begin
              state_next.vowel = NONE_IDX;
              if (state.implied) begin
                state_next = IDLE_STATE;
              end
            end
          end else begin
            state_next = IDLE_STATE;
          end
        end
      end
      MODE_RESET: begin
        state_next = IDLE_STATE;
      end
      MODE_ENTER, MODE_TAB: begin
        snap_next  = state;
        state_next = IDLE_STATE;
      end
      MODE_KEY: begin
        if (key_ok) begin
          if (!lk.hit && !vk.hit) begin
            // Unmapped key: flush the preview and fall back to idle.
            snap_next  = state;
            state_next = IDLE_STATE;
          end else begin
            consumed_next = 1'b1;
            show_next     = 1'b1;
            if (vk.hit) begin
              // Vowel key.
              if (!state.composing) begin
                state_next = '{1'b1, 1'b1, SILENT_LEAD, vk.idx, 5'd0};
              end else if (state.vowel == NONE_IDX) begin
                state_next.vowel = vk.idx;
              end else if (state.tail != 5'd0) begin
                // The tail, or its second half, moves to the next syllable.
                if (split_first(state.tail) != 5'd0) begin
                  snap_next  = '{1'b1, 1'b0, state.lead, state.vowel,
                                 split_first(state.tail)};
                  state_next = '{1'b1, 1'b0, split_second(state.tail), vk.idx, 5'd0};
                end else begin
                  snap_next  = '{1'b1, 1'b0, state.lead, state.vowel, 5'd0};
                  state_next = '{1'b1, 1'b0, (lt != NONE_IDX) ? lt : SILENT_LEAD,
                                 vk.idx, 5'd0};
                end
              end else if (cv.hit) begin
                state_next.vowel = cv.idx;
              end else begin
                snap_next  = state;
                state_next = '{1'b1, 1'b1, SILENT_LEAD, vk.idx, 5'd0};
              end
            end else begin
              // Consonant key.
              if (!state.composing) begin
                state_next = '{1'b1, 1'b0, lk.idx, NONE_IDX, 5'd0};
              end else if (state.vowel == NONE_IDX ||
                           (state.implied && state.tail == 5'd0) ||
                           tl == 5'd0) begin
                snap_next  = state;
                state_next = '{1'b1, 1'b0, lk.idx, NONE_IDX, 5'd0};
              end else if (state.tail == 5'd0) begin
                state_next.tail = tl;
              end else if (ct.hit) begin
                state_next.tail = ct.idx;
              end else begin
                snap_next  = state;
                state_next = '{1'b1, 1'b0, lk.idx, NONE_IDX, 5'd0};
              end
            end
          end
        end
      end
      default: begin
        state_next = state;
      end
    endcase
  end

  // Composition state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE_STATE;
    end else if (cmd.eval) begin
      state <= state_next;
    end
  end

  // Step results held for the build cycle.
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      snap     <= snap_next;
      consumed <= consumed_next;
      show     <= show_next;
    end
  end

  // Code point build for preview and commit.
  always_comb begin
    pre_code    = show ? preview(state) : '0;
    commit_code = preview(snap);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result <= {5'd0, commit_code, (commit_code != '0), pre_code,
                 (pre_code != '0), consumed};
    end
  end

endmodule

`default_nettype wire

>>> design/hsc_ctrl.sv
// ----------------------------------------------------------------------------
// hsc_ctrl
// Sequencer for the composer: transfer handshakes and datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module hsc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hsc_pkg::hsc_cmd_t      cmd
);
  import hsc_pkg::*;

  hsc_state_t state;
  hsc_state_t state_next;
  logic       can_load;
  logic       out_valid_next;

  assign can_load = !out_valid || out_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_BUILD;
      end
      S_BUILD: begin
        // Loading the result frees the event register for the next transfer.
        if (can_load) begin
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          if (in_valid) begin
            cmd.load_in = 1'b1;
            state_next  = S_EVAL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  a_accept_eval : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EVAL))
    else $error("accepted event did not enter evaluation");

  a_eval_build : assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |=> (state == S_BUILD))
    else $error("evaluation not followed by build");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.load_out)
    else $error("pending result overwritten");

  a_ready_eval : assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> !in_ready)
    else $error("event accepted while one is being evaluated");

endmodule

`default_nettype wire

>>> design/hangul_two_set_composer.sv
// ----------------------------------------------------------------------------
// hangul_two_set_composer
// Two-set Hangul composition automaton driven by keyboard event transfers.
// ----------------------------------------------------------------------------
// Each event transfer yields exactly one result transfer. After an event is
// taken, the block steps the automaton (key lookup and state update) in its
// evaluate step and then builds the preview and commit code points into the
// result register in its build step. A new event is taken in the same cycle
// the result is loaded, but none while one is being evaluated. While a result
// waits downstream, one more event can still be taken and evaluated, but it
// then holds in its build step and no further event is taken until the
// waiting result leaves.
`default_nettype none

module hangul_two_set_composer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [20:0] key_code, [23:21] zero
  input  wire logic [3:0]  s_tuser,   // [3:0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // [0] consumed, [1] preedit_valid,
                                      // [17:2] preedit_code, [18] commit_valid,
                                      // [34:19] commit_code, [39:35] zero
);
  import hsc_pkg::*;

  hsc_cmd_t cmd;

  hsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  hsc_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .in_mode (s_tuser),
    .in_key  (s_tdata[KEY_W-1:0]),
    .result  (m_tdata)
  );

endmodule

`default_nettype wire

>>> dv/tb_hangul_two_set_composer.sv
// ----------------------------------------------------------------------------
// tb_hangul_two_set_composer
// Self-checking bench for the two-set Hangul composer. Keyboard events go in
// through a stream driver and a scoreboard predicts every result transfer
// from its own copy of the composition automaton.
// ----------------------------------------------------------------------------
// The run starts with a directed list that covers ignored events, the silent
// lead, tail clusters, compound vowels, undo and commits. Random syllable-like
// key sequences follow, mixed with noise. Both sides idle in random bursts,
// the receiver holds off for a long stretch in the first two random phases,
// and the sender waits for the pipeline to drain between phases.
`default_nettype none

module tb_hangul_two_set_composer;
  timeunit 1ns;
  timeprecision 1ps;

  import hsc_pkg::*;

  localparam logic [4:0]  NO_TAIL     = 5'd0;
  localparam logic [20:0] KEY_LIMIT   = 21'h7F;
  localparam logic [3:0]  MODE_SPARE  = 4'd5;
  localparam int          HOLD_CYCLES = 300;
  localparam int          STALL_LIMIT = 2000;

  // One keyboard event as it travels on the input side.
  typedef struct packed {
    logic [3:0]  mode;
    logic [20:0] key;
  } key_event_t;

  // One result as it travels on m_tdata, highest field first.
  typedef struct packed {
    logic [4:0]  pad;
    logic [15:0] commit_code;
    logic        commit_flag;
    logic [15:0] preedit_code;
    logic        preedit_flag;
    logic        consumed;
  } composer_out_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // [20:0] key_code, [23:21] zero
  logic [3:0]  s_tuser  = '0;   // [3:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [0] consumed, [1] preedit_valid, [17:2] preedit_code,
                                // [18] commit_valid, [34:19] commit_code, [39:35] zero

  hangul_two_set_composer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Keyboard layout and jamo tables of the automaton.
  logic [6:0]  lead_keys [19] = '{7'h72, 7'h52, 7'h73, 7'h65, 7'h45, 7'h66, 7'h61, 7'h71,
                                  7'h51, 7'h74, 7'h54, 7'h64, 7'h77, 7'h57, 7'h63, 7'h7A,
                                  7'h78, 7'h76, 7'h67};
  logic [6:0]  vowel_keys [21] = '{7'h6B, 7'h6F, 7'h69, 7'h4F, 7'h6A, 7'h70, 7'h75, 7'h50,
                                   7'h68, 7'h00, 7'h00, 7'h00, 7'h79, 7'h6E, 7'h00, 7'h00,
                                   7'h00, 7'h62, 7'h6D, 7'h00, 7'h6C};
  logic [4:0]  tail_form [19] = '{5'd1, 5'd2, 5'd4, 5'd7, 5'd0, 5'd8, 5'd16, 5'd17, 5'd0,
                                  5'd19, 5'd20, 5'd21, 5'd22, 5'd0, 5'd23, 5'd24, 5'd25,
                                  5'd26, 5'd27};
  logic [4:0]  lead_form [28] = '{5'd31, 5'd0, 5'd1, 5'd31, 5'd2, 5'd31, 5'd31, 5'd3, 5'd5,
                                  5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd6,
                                  5'd7, 5'd31, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14, 5'd15,
                                  5'd16, 5'd17, 5'd18};
  logic [4:0]  cluster_head [28] = '{5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd4, 5'd4, 5'd0, 5'd0,
                                     5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd8, 5'd0, 5'd0,
                                     5'd17, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
                                     5'd0};
  logic [4:0]  cluster_lead [28] = '{5'd0, 5'd0, 5'd0, 5'd9, 5'd0, 5'd12, 5'd18, 5'd0, 5'd0,
                                     5'd0, 5'd6, 5'd7, 5'd9, 5'd16, 5'd17, 5'd18, 5'd0, 5'd0,
                                     5'd9, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
                                     5'd0};
  logic [4:0]  vowel_head [21] = '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
                                   5'd31, 5'd8, 5'd8, 5'd8, 5'd31, 5'd31, 5'd13, 5'd13,
                                   5'd13, 5'd31, 5'd31, 5'd18, 5'd31};
  logic [4:0]  vowel_add [21] = '{5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
                                  5'd31, 5'd0, 5'd1, 5'd20, 5'd31, 5'd31, 5'd4, 5'd5, 5'd20,
                                  5'd31, 5'd31, 5'd20, 5'd31};
  logic [15:0] lead_compat [19] = '{16'h3131, 16'h3132, 16'h3134, 16'h3137, 16'h3138,
                                    16'h3139, 16'h3141, 16'h3142, 16'h3143, 16'h3145,
                                    16'h3146, 16'h3147, 16'h3148, 16'h3149, 16'h314A,
                                    16'h314B, 16'h314C, 16'h314D, 16'h314E};

  // Key pairs that build compound vowels and tail clusters, first key high.
  logic [13:0] vowel_pairs [7] = '{{7'h68, 7'h6B}, {7'h68, 7'h6F}, {7'h68, 7'h6C},
                                   {7'h6E, 7'h6A}, {7'h6E, 7'h70}, {7'h6E, 7'h6C},
                                   {7'h6D, 7'h6C}};
  logic [13:0] cluster_pairs [11] = '{{7'h72, 7'h74}, {7'h73, 7'h77}, {7'h73, 7'h67},
                                      {7'h66, 7'h72}, {7'h66, 7'h61}, {7'h66, 7'h71},
                                      {7'h66, 7'h74}, {7'h66, 7'h78}, {7'h66, 7'h76},
                                      {7'h66, 7'h67}, {7'h71, 7'h74}};

  // Predicted composition state.
  logic       comp_busy   = 1'b0;
  logic       comp_silent = 1'b0;
  logic [4:0] comp_lead   = NONE_IDX;
  logic [4:0] comp_vowel  = NONE_IDX;
  logic [4:0] comp_tail   = 5'd0;

  key_event_t    pend_q[$];
  composer_out_t exp_q[$];
  key_event_t    next_ev;
  composer_out_t got;
  composer_out_t want;

  logic in_taken     = 1'b0;
  int   send_gap     = 0;
  int   recv_gap     = 0;
  int   hold_left    = 0;
  int   hold_ask     = 0;
  int   hold_seen    = 0;
  int   idle_odds    = 0;
  int   stall_cycles = 0;
  int   fail_count   = 0;
  int   live_items   = 0;

  function automatic void set_composer(logic busy, logic silent, logic [4:0] l,
                                       logic [4:0] v, logic [4:0] t);
    comp_busy   = busy;
    comp_silent = silent;
    comp_lead   = l;
    comp_vowel  = v;
    comp_tail   = t;
  endfunction

  function automatic void clear_composer();
    set_composer(1'b0, 1'b0, NONE_IDX, NONE_IDX, NO_TAIL);
  endfunction

  function automatic logic [15:0] vowel_compat(logic [4:0] v);
    return (v < N_VOWEL) ? 16'(int'(VOWEL_BASE) + int'(v)) : BAD_CODE;
  endfunction

  function automatic logic [15:0] syllable_of(logic [4:0] l, logic [4:0] v, logic [4:0] t);
    if (l >= N_LEAD || v >= N_VOWEL || t >= N_TAIL) return BAD_CODE;
    return 16'(int'(SYL_BASE) + (int'(l) * 21 + int'(v)) * 28 + int'(t));
  endfunction

  // Code point shown for the syllable under composition.
  function automatic logic [15:0] composer_preview();
    logic has_lead;
    logic has_vowel;
    has_lead  = comp_lead != NONE_IDX;
    has_vowel = comp_vowel != NONE_IDX;
    if (!comp_busy) return '0;
    if (comp_silent && has_vowel && comp_tail == NO_TAIL) return vowel_compat(comp_vowel);
    if (has_lead && has_vowel) return syllable_of(comp_lead, comp_vowel, comp_tail);
    if (has_lead) return (comp_lead < N_LEAD) ? lead_compat[comp_lead] : BAD_CODE;
    if (has_vowel) return vowel_compat(comp_vowel);
    return '0;
  endfunction

  function automatic int vowel_pair(logic [4:0] a, logic [4:0] b);
    for (int v = 0; v < 21; v++) begin
      if (vowel_head[v] == a && vowel_add[v] == b) return v;
    end
    return -1;
  endfunction

  function automatic int tail_pair(logic [4:0] t, logic [4:0] l);
    for (int c = 0; c < 28; c++) begin
      if (cluster_head[c] != 5'd0 && cluster_head[c] == t && cluster_lead[c] == l) return c;
    end
    return -1;
  endfunction

  // A vowel key; returns the committed code point, zero when none.
  function automatic logic [15:0] take_vowel(logic [4:0] v);
    logic [15:0] code;
    logic [4:0]  t;
    logic [4:0]  m;
    int          c;
    code = '0;
    if (!comp_busy) begin
      set_composer(1'b1, 1'b1, SILENT_LEAD, v, NO_TAIL);
    end else if (comp_vowel == NONE_IDX) begin
      comp_vowel = v;
    end else if (comp_tail != NO_TAIL) begin
      // The tail, or the second half of a cluster, moves into the next syllable.
      t = (comp_tail < N_TAIL) ? comp_tail : NO_TAIL;
      if (cluster_head[t] != 5'd0) begin
        code = syllable_of(comp_lead, comp_vowel, cluster_head[t]);
        set_composer(1'b1, 1'b0, cluster_lead[t], v, NO_TAIL);
      end else begin
        m = lead_form[t];
        code = syllable_of(comp_lead, comp_vowel, NO_TAIL);
        set_composer(1'b1, 1'b0, (m != NONE_IDX) ? m : SILENT_LEAD, v, NO_TAIL);
      end
    end else begin
      c = vowel_pair(comp_vowel, v);
      if (c >= 0) begin
        comp_vowel = 5'(c);
      end else begin
        code = composer_preview();
        set_composer(1'b1, 1'b1, SILENT_LEAD, v, NO_TAIL);
      end
    end
    return code;
  endfunction

  // A consonant key; returns the committed code point, zero when none.
  function automatic logic [15:0] take_lead(logic [4:0] l);
    logic [15:0] code;
    logic [4:0]  t;
    int          c;
    code = '0;
    t = tail_form[l];
    if (!comp_busy) begin
      set_composer(1'b1, 1'b0, l, NONE_IDX, NO_TAIL);
    end else if (comp_vowel == NONE_IDX) begin
      code = composer_preview();
      set_composer(1'b1, 1'b0, l, NONE_IDX, NO_TAIL);
    end else if (comp_silent && comp_tail == NO_TAIL) begin
      // A bare vowel never takes a tail: it is committed on its own.
      code = vowel_compat(comp_vowel);
      set_composer(1'b1, 1'b0, l, NONE_IDX, NO_TAIL);
    end else if (t == NO_TAIL) begin
      code = composer_preview();
      set_composer(1'b1, 1'b0, l, NONE_IDX, NO_TAIL);
    end else if (comp_tail == NO_TAIL) begin
      comp_tail = t;
    end else begin
      c = tail_pair(comp_tail, l);
      if (c >= 0) begin
        comp_tail = 5'(c);
      end else begin
        code = composer_preview();
        set_composer(1'b1, 1'b0, l, NONE_IDX, NO_TAIL);
      end
    end
    return code;
  endfunction

  // Backspace removes the newest element of the syllable.
  function automatic void undo_element();
    logic [4:0] b;
    if (comp_tail != NO_TAIL) begin
      comp_tail = (comp_tail < N_TAIL) ? cluster_head[comp_tail] : NO_TAIL;
    end else if (comp_vowel != NONE_IDX) begin
      b = (comp_vowel < N_VOWEL) ? vowel_head[comp_vowel] : NONE_IDX;
      if (b != NONE_IDX) begin
        comp_vowel = b;
      end else begin
        comp_vowel = NONE_IDX;
        if (comp_silent) clear_composer();
      end
    end else begin
      clear_composer();
    end
  endfunction

  // Advances the predicted automaton by one event and returns its result.
  function automatic composer_out_t compose_step(logic [3:0] mode, logic [20:0] key);
    composer_out_t r;
    logic [15:0]   code;
    logic          show;
    int            lead_hit;
    int            vowel_hit;
    r = '0;
    code = '0;
    show = 1'b0;
    lead_hit = -1;
    vowel_hit = -1;
    case (mode)
      MODE_BACKSPACE: begin
        if (comp_busy) begin
          r.consumed = 1'b1;
          undo_element();
          show = 1'b1;
        end
      end
      MODE_RESET: begin
        clear_composer();
      end
      MODE_ENTER, MODE_TAB: begin
        code = composer_preview();
        clear_composer();
      end
      MODE_KEY: begin
        if (key <= KEY_LIMIT) begin
          for (int i = 0; i < 19; i++) begin
            if (21'(lead_keys[i]) == key) lead_hit = i;
          end
          for (int i = 0; i < 21; i++) begin
            if (key != 21'd0 && 21'(vowel_keys[i]) == key) vowel_hit = i;
          end
          if (lead_hit < 0 && vowel_hit < 0) begin
            code = composer_preview();
            clear_composer();
          end else begin
            r.consumed = 1'b1;
            code = (vowel_hit >= 0) ? take_vowel(5'(vowel_hit)) : take_lead(5'(lead_hit));
            show = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (show) r.preedit_code = composer_preview();
    r.preedit_flag = r.preedit_code != 16'd0;
    r.commit_flag  = code != 16'd0;
    r.commit_code  = code;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] w, logic [15:0] g);
    if (w !== g) begin
      fail_count++;
      $display("%0t: %s expected 0x%h, got 0x%h", $time, name, w, g);
    end
  endfunction

  // Scoreboard: predicts on every input transfer, checks every output transfer.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst) begin
      clear_composer();
    end else begin
      if (m_tvalid && m_tready) begin
        got = composer_out_t'(m_tdata);
        if (exp_q.size() == 0) begin
          fail_count++;
          $display("%0t: result 0x%h with nothing expected", $time, m_tdata);
        end else begin
          want = exp_q.pop_front();
          check_field("consumed", 16'(want.consumed), 16'(got.consumed));
          check_field("preedit_valid", 16'(want.preedit_flag), 16'(got.preedit_flag));
          check_field("preedit_code", want.preedit_code, got.preedit_code);
          check_field("commit_valid", 16'(want.commit_flag), 16'(got.commit_flag));
          check_field("commit_code", want.commit_code, got.commit_code);
          check_field("padding", 16'(want.pad), 16'(got.pad));
        end
      end
      if (s_tvalid && s_tready) begin
        in_taken = 1'b1;
        exp_q.push_back(compose_step(s_tuser, s_tdata[20:0]));
      end
      if (in_taken || (m_tvalid && m_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // Event driver: holds an offer until it is taken, idles in random bursts.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pend_q.size() != 0) begin
        next_ev = pend_q.pop_front();
        s_tuser <= next_ev.mode;
        s_tdata <= {3'b000, next_ev.key};
        s_tvalid <= 1'b1;
        if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
          send_gap = $urandom_range(1, 12);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall bursts plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES - 1;
      m_tready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
        recv_gap = $urandom_range(1, 12);
      end
    end
  end

  task automatic push_event(logic [3:0] mode, logic [20:0] key);
    key_event_t ev;
    ev.mode = mode;
    ev.key  = key;
    pend_q.push_back(ev);
    if (!(mode >= MODE_SPARE || (mode == MODE_KEY && key > KEY_LIMIT))) live_items++;
  endtask

  // Optional lead, a vowel or vowel pair, then an optional tail or cluster and an optional backspace.
  task automatic push_syllable();
    logic [13:0] pair;
    int          pick;
    if ($urandom_range(0, 9) != 0) push_event(MODE_KEY, 21'(lead_keys[$urandom_range(0, 18)]));
    if ($urandom_range(0, 2) == 0) begin
      pair = vowel_pairs[$urandom_range(0, 6)];
      push_event(MODE_KEY, 21'(pair[13:7]));
      push_event(MODE_KEY, 21'(pair[6:0]));
    end else begin
      pick = $urandom_range(0, 20);
      while (vowel_keys[pick] == 7'h00) pick = $urandom_range(0, 20);
      push_event(MODE_KEY, 21'(vowel_keys[pick]));
    end
    case ($urandom_range(0, 3))
      1: push_event(MODE_KEY, 21'(lead_keys[$urandom_range(0, 18)]));
      2: begin
        pair = cluster_pairs[$urandom_range(0, 10)];
        push_event(MODE_KEY, 21'(pair[13:7]));
        push_event(MODE_KEY, 21'(pair[6:0]));
      end
      default: ;
    endcase
    if ($urandom_range(0, 5) == 0) push_event(MODE_BACKSPACE, 21'($urandom));
  endtask

  task automatic push_noise();
    case ($urandom_range(0, 7))
      0: push_event(MODE_KEY, 21'($urandom_range(0, 127)));
      1: push_event(MODE_KEY, 21'($urandom_range(128, 21'h1FFFFF)));
      2: push_event(4'($urandom_range(5, 15)), 21'($urandom));
      3: push_event(MODE_ENTER, 21'($urandom));
      4: push_event(MODE_TAB, 21'($urandom));
      5: push_event(MODE_RESET, 21'($urandom));
      default: push_event(MODE_BACKSPACE, 21'($urandom));
    endcase
  endtask

  task automatic push_random(int target);
    live_items = 0;
    while (live_items < target) begin
      if ($urandom_range(0, 9) < 7) begin
        push_syllable();
      end else begin
        push_noise();
      end
    end
  endtask

  // Sender pause: nothing queued, nothing offered, nothing outstanding.
  task automatic wait_drained();
    while (pend_q.size() != 0 || s_tvalid || exp_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("tb_hangul_two_set_composer NOT OK");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed events: ignored items, silent lead, clusters, compounds, commits.
    idle_odds = 6;
    push_event(MODE_BACKSPACE, 21'd0);
    push_event(MODE_KEY, 21'd0);
    push_event(MODE_KEY, 21'h1FFFFF);
    push_event(MODE_KEY, 21'h80);
    push_event(4'd15, 21'h1FFFFF);
    push_event(MODE_SPARE, 21'd0);
    push_event(MODE_KEY, 21'("k"));
    push_event(MODE_KEY, 21'("r"));
    push_event(MODE_KEY, 21'("k"));
    push_event(MODE_KEY, 21'("f"));
    push_event(MODE_KEY, 21'("r"));
    push_event(MODE_KEY, 21'("k"));
    push_event(MODE_KEY, 21'("Q"));
    push_event(MODE_KEY, 21'("h"));
    push_event(MODE_KEY, 21'("k"));
    push_event(MODE_BACKSPACE, 21'd0);
    push_event(MODE_KEY, 21'("s"));
    push_event(MODE_KEY, 21'("g"));
    push_event(MODE_BACKSPACE, 21'd0);
    push_event(MODE_KEY, 21'("p"));
    push_event(MODE_KEY, KEY_LIMIT);
    push_event(MODE_KEY, 21'("m"));
    push_event(MODE_KEY, 21'("l"));
    push_event(MODE_ENTER, 21'd0);
    push_event(MODE_KEY, 21'("d"));
    push_event(MODE_TAB, 21'd0);
    push_event(MODE_KEY, 21'("q"));
    push_event(MODE_RESET, 21'd0);
    push_event(MODE_KEY, 21'("W"));
    push_event(MODE_KEY, 21'("u"));
    push_event(MODE_BACKSPACE, 21'd0);
    push_event(MODE_BACKSPACE, 21'd0);
    push_event(MODE_BACKSPACE, 21'd0);
    wait_drained();

    // Heavy idling, with the receiver holding off while events keep coming.
    idle_odds = 3;
    push_random(450);
    hold_ask++;
    wait_drained();

    // Light idling and a second hold-off.
    idle_odds = 12;
    push_random(450);
    hold_ask++;
    wait_drained();

    // Back-to-back traffic with no idling on either side.
    idle_odds = 0;
    push_random(300);
    wait_drained();
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_hangul_two_set_composer OK");
    end else begin
      $display("tb_hangul_two_set_composer NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
